>>> rtl/core/qcs_pkg.sv
// ----------------------------------------------------------------------------
// qcs_pkg: shared types and constants of the quadrature counter
// Widths, register indexes, sequencer states and divider handshake structs.
// ----------------------------------------------------------------------------
package qcs_pkg;

  // width of the reported position value
  localparam int VALUE_WIDTH = 16;
  // step size register width
  localparam int STEP_W      = 8;
  // raw count holds value times step
  localparam int RAW_W       = VALUE_WIDTH + STEP_W;
  // signed product of a value and a zero-extended step
  localparam int PROD_W      = VALUE_WIDTH + STEP_W + 1;
  // iteration counter of the serial divider
  localparam int CNT_W       = $clog2(RAW_W);

  // saturation limits as magnitudes
  localparam logic [RAW_W-1:0] VMAX_MAG = RAW_W'((2 ** (VALUE_WIDTH - 1)) - 1);
  localparam logic [RAW_W-1:0] VMIN_MAG = RAW_W'(2 ** (VALUE_WIDTH - 1));
  localparam logic [VALUE_WIDTH-1:0] VMAX_VAL = VALUE_WIDTH'((2 ** (VALUE_WIDTH - 1)) - 1);
  localparam logic [VALUE_WIDTH-1:0] VMIN_VAL = VALUE_WIDTH'(2 ** (VALUE_WIDTH - 1));

  // configuration register indexes
  localparam logic [1:0] REG_STEP = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;
  localparam logic [1:0] REG_INIT = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_e;

  // divider request and response
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_rsp_t;

endpackage

>>> rtl/core/qcs_div.sv
// ----------------------------------------------------------------------------
// qcs_div: serial signed-by-unsigned divider
// Restoring shift-subtract, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module qcs_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qcs_pkg::div_req_t                req_i,
  input  logic signed [qcs_pkg::RAW_W-1:0] dividend_i,
  input  logic [qcs_pkg::STEP_W-1:0]       divisor_i,
  output qcs_pkg::div_rsp_t                rsp_o,
  output logic [qcs_pkg::RAW_W-1:0]        quot_mag_o,
  output logic                             quot_neg_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [qcs_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [qcs_pkg::STEP_W-1:0]   rem_q, rem_d;
  logic [qcs_pkg::STEP_W-1:0]   div_q, div_d;
  logic [qcs_pkg::RAW_W-1:0]    dvd_q, dvd_d;
  logic                         neg_q, neg_d;
  logic [qcs_pkg::STEP_W:0]     trial;
  logic [qcs_pkg::STEP_W:0]     diff;
  logic                         ge;
  logic [qcs_pkg::RAW_W-1:0]    abs_dvd;

  // magnitude of the dividend, the most negative value fits unsigned
  assign abs_dvd = dividend_i[qcs_pkg::RAW_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // one restoring step
  assign trial = {rem_q, dvd_q[qcs_pkg::RAW_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = qcs_pkg::CNT_W'(qcs_pkg::RAW_W - 1);
      rem_d  = '0;
      div_d  = divisor_i;
      dvd_d  = abs_dvd;
      neg_d  = dividend_i[qcs_pkg::RAW_W-1];
    end else if (busy_q) begin
      rem_d = ge ? diff[qcs_pkg::STEP_W-1:0] : trial[qcs_pkg::STEP_W-1:0];
      dvd_d = {dvd_q[qcs_pkg::RAW_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    dvd_q <= dvd_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign quot_mag_o = dvd_q;
  assign quot_neg_o = neg_q;

endmodule

>>> rtl/core/quadrature_counter_clamped_scaled.sv
// ----------------------------------------------------------------------------
// quadrature_counter_clamped_scaled: x4 quadrature position counter
// Edge beats step a raw count, clamp it to scaled bounds and report count/step.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------------------------
//   in      | in  | in_valid_i/in_stall_o  | edge_pin_i edge_rising_i
//           |     |                        | other_level_i
//   out     | out | out_valid_o/out_stall_i| position_value_o
//   cfg     | in  | cfg_we_i               | cfg_addr_i cfg_wdata_i
//
// An edge beat goes from accept to result through two passes through the shared
// multiplier for the bounds, a clamp step, then the serial divider at one
// quotient bit per cycle.
// in_stall_o is high from accept until the sequencer is idle again.
// A finished result waits in the output register; a new beat may be taken
// meanwhile and waits at its end until the register is free.
// Reset gives step 1, full-range bounds and a raw count of zero.
// ----------------------------------------------------------------------------
module quadrature_counter_clamped_scaled (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    edge_pin_i,
  input  logic                                    edge_rising_i,
  input  logic                                    other_level_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [qcs_pkg::VALUE_WIDTH-1:0]  position_value_o,
  input  logic                                    cfg_we_i,
  input  logic [1:0]                              cfg_addr_i,
  input  logic [qcs_pkg::VALUE_WIDTH-1:0]         cfg_wdata_i
);

  qcs_pkg::state_e state_q, state_d;

  logic [qcs_pkg::STEP_W-1:0]             step_q;
  logic signed [qcs_pkg::VALUE_WIDTH-1:0] min_q, max_q;
  logic signed [qcs_pkg::RAW_W-1:0]       raw_q, raw_d;
  logic signed [qcs_pkg::RAW_W-1:0]       lo_q, hi_q;
  logic                                   up_q;
  logic                                   out_valid_q;
  logic [qcs_pkg::VALUE_WIDTH-1:0]        out_q;

  logic [qcs_pkg::STEP_W-1:0]             st_eff;
  logic signed [qcs_pkg::VALUE_WIDTH-1:0] mul_a;
  logic signed [qcs_pkg::PROD_W-1:0]      prod;
  logic signed [qcs_pkg::RAW_W:0]         sum;
  logic signed [qcs_pkg::RAW_W:0]         lo_ext, hi_ext;
  logic [qcs_pkg::VALUE_WIDTH-1:0]        sat_val;
  logic [qcs_pkg::RAW_W-1:0]              neg_mag;
  logic                                   in_acc;
  logic                                   init_wr;
  logic                                   load_lo, load_hi, load_raw, load_out;

  qcs_pkg::div_req_t                      div_req;
  qcs_pkg::div_rsp_t                      div_rsp;
  logic [qcs_pkg::RAW_W-1:0]              quot_mag;
  logic                                   quot_neg;

  // a zero step counts as one
  assign st_eff = (step_q == '0) ? qcs_pkg::STEP_W'(1) : step_q;

  // shared multiplier: init load on config, bounds under the sequencer
  assign init_wr = cfg_we_i && (cfg_addr_i == qcs_pkg::REG_INIT);
  always_comb begin
    if (init_wr) begin
      mul_a = $signed(cfg_wdata_i);
    end else if (state_q == qcs_pkg::ST_MUL_LO) begin
      mul_a = min_q;
    end else begin
      mul_a = max_q;
    end
  end
  assign prod = qcs_pkg::PROD_W'(mul_a * $signed({1'b0, st_eff}));

  // step and clamp, lower bound tested first
  assign sum    = $signed({raw_q[qcs_pkg::RAW_W-1], raw_q}) + (up_q ? 2'sd1 : -2'sd1);
  assign lo_ext = {lo_q[qcs_pkg::RAW_W-1], lo_q};
  assign hi_ext = {hi_q[qcs_pkg::RAW_W-1], hi_q};
  always_comb begin
    if (sum < lo_ext) begin
      raw_d = lo_q;
    end else if (sum > hi_ext) begin
      raw_d = hi_q;
    end else begin
      raw_d = sum[qcs_pkg::RAW_W-1:0];
    end
  end

  // saturate the quotient to the value range
  assign neg_mag = ~quot_mag + 1'b1;
  always_comb begin
    if (quot_neg) begin
      sat_val = (quot_mag > qcs_pkg::VMIN_MAG) ? qcs_pkg::VMIN_VAL
                                               : neg_mag[qcs_pkg::VALUE_WIDTH-1:0];
    end else begin
      sat_val = (quot_mag > qcs_pkg::VMAX_MAG) ? qcs_pkg::VMAX_VAL
                                               : quot_mag[qcs_pkg::VALUE_WIDTH-1:0];
    end
  end

  // sequencer: next state and controls
  assign in_acc = in_valid_i && !in_stall_o;
  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    load_lo       = 1'b0;
    load_hi       = 1'b0;
    load_raw      = 1'b0;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    case (state_q)
      qcs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = qcs_pkg::ST_MUL_LO;
        end
      end
      qcs_pkg::ST_MUL_LO: begin
        load_lo = 1'b1;
        state_d = qcs_pkg::ST_MUL_HI;
      end
      qcs_pkg::ST_MUL_HI: begin
        load_hi = 1'b1;
        state_d = qcs_pkg::ST_UPDATE;
      end
      qcs_pkg::ST_UPDATE: begin
        load_raw      = 1'b1;
        div_req.start = 1'b1;
        state_d       = qcs_pkg::ST_DIV;
      end
      qcs_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = qcs_pkg::ST_DONE;
        end
      end
      qcs_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = qcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qcs_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers and raw count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= qcs_pkg::STEP_W'(1);
      min_q  <= $signed(qcs_pkg::VMIN_VAL);
      max_q  <= $signed(qcs_pkg::VMAX_VAL);
      raw_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          qcs_pkg::REG_STEP: step_q <= cfg_wdata_i[qcs_pkg::STEP_W-1:0];
          qcs_pkg::REG_MIN:  min_q  <= $signed(cfg_wdata_i);
          qcs_pkg::REG_MAX:  max_q  <= $signed(cfg_wdata_i);
          qcs_pkg::REG_INIT: raw_q  <= prod[qcs_pkg::RAW_W-1:0];
          default: ;
        endcase
      end
      if (load_raw) begin
        raw_q <= raw_d;
      end
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      up_q <= edge_rising_i ^ other_level_i ^ edge_pin_i;
    end
    if (load_lo) begin
      lo_q <= prod[qcs_pkg::RAW_W-1:0];
    end
    if (load_hi) begin
      hi_q <= prod[qcs_pkg::RAW_W-1:0];
    end
    if (load_out) begin
      out_q <= sat_val;
    end
  end

  // serial divider
  qcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (raw_d),
    .divisor_i  (st_eff),
    .rsp_o      (div_rsp),
    .quot_mag_o (quot_mag),
    .quot_neg_o (quot_neg)
  );

  assign out_valid_o      = out_valid_q;
  assign position_value_o = $signed(out_q);

  // a result appears only out of the final state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == qcs_pkg::ST_DONE))
    else $error("output beat without a finished item");

  // with ordered bounds the count lands inside them
  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qcs_pkg::ST_UPDATE && lo_q <= hi_q) |=> (raw_q >= lo_q && raw_q <= hi_q))
    else $error("raw count outside bounds after update");

  // the divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == qcs_pkg::ST_DIV))
    else $error("divider done outside the divide state");

  // an accepted beat starts the bound computation
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == qcs_pkg::ST_MUL_LO && in_stall_o))
    else $error("accepted beat did not start the sequence");

endmodule

>>> bench/qcs_position_checker.sv
// ----------------------------------------------------------------------------
// qcs_position_checker: scoreboard for the quadrature position counter
// Watches the edge, result and register write ports, keeps its own copy of
// the raw count and the registers, and compares each result beat in order.
// ----------------------------------------------------------------------------
module qcs_position_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_i,
  input  logic                                   edge_pin_i,
  input  logic                                   edge_rising_i,
  input  logic                                   other_level_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_stall_i,
  input  logic signed [qcs_pkg::VALUE_WIDTH-1:0] position_value_i,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_addr_i,
  input  logic [qcs_pkg::VALUE_WIDTH-1:0]        cfg_wdata_i,
  output int                                     mismatch_cnt_o,
  output int                                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMAX = (64'sd1 <<< (qcs_pkg::VALUE_WIDTH - 1)) - 64'sd1;
  localparam longint QMIN = -QMAX - 64'sd1;

  // shadow registers and raw count
  logic [qcs_pkg::STEP_W-1:0]             step_q;
  logic signed [qcs_pkg::VALUE_WIDTH-1:0] min_q;
  logic signed [qcs_pkg::VALUE_WIDTH-1:0] max_q;
  logic signed [qcs_pkg::VALUE_WIDTH-1:0] init_q;
  logic signed [qcs_pkg::RAW_W-1:0]       raw_q;

  // positions still owed by the block, oldest first
  logic signed [qcs_pkg::VALUE_WIDTH-1:0] position_q[$];
  int                                     mismatch_cnt;

  // a zero step counts as one
  function automatic longint eff_step();
    return (step_q == '0) ? 64'sd1 : longint'(step_q);
  endfunction

  // one edge: move the count, clamp it, report count over step
  function automatic logic signed [qcs_pkg::VALUE_WIDTH-1:0] step_position(
    input logic pin_b,
    input logic rising,
    input logic other
  );
    longint st;
    longint lo;
    longint hi;
    longint cnt;
    longint quo;
    logic   up;
    st  = eff_step();
    lo  = longint'(min_q) * st;
    hi  = longint'(max_q) * st;
    cnt = longint'(raw_q);
    up  = pin_b ? (rising == other) : (rising != other);
    cnt = up ? cnt + 64'sd1 : cnt - 64'sd1;
    // lower bound tested first; with crossed bounds a count under it takes it, else the upper bound
    if (cnt < lo) begin
      cnt = lo;
    end else if (cnt > hi) begin
      cnt = hi;
    end
    raw_q = cnt[qcs_pkg::RAW_W-1:0];
    quo = cnt / st;
    if (quo > QMAX) begin
      quo = QMAX;
    end else if (quo < QMIN) begin
      quo = QMIN;
    end
    return quo[qcs_pkg::VALUE_WIDTH-1:0];
  endfunction

  // track writes, beats in and beats out
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [qcs_pkg::VALUE_WIDTH-1:0] want;
    longint                                 init_raw;
    if (!rst_ni) begin
      step_q         = 8'd1;
      min_q          = 16'sh8000;
      max_q          = 16'sh7fff;
      init_q         = '0;
      raw_q          = '0;
      mismatch_cnt   = 0;
      position_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      // register write
      if (cfg_we_i) begin
        case (cfg_addr_i)
          qcs_pkg::REG_STEP: step_q = cfg_wdata_i[qcs_pkg::STEP_W-1:0];
          qcs_pkg::REG_MIN:  min_q = cfg_wdata_i;
          qcs_pkg::REG_MAX:  max_q = cfg_wdata_i;
          qcs_pkg::REG_INIT: begin
            init_q   = cfg_wdata_i;
            init_raw = longint'(init_q) * eff_step();
            raw_q    = init_raw[qcs_pkg::RAW_W-1:0];
          end
          default: ;
        endcase
      end
      // result beat against the oldest position owed
      if (out_valid_i && !out_stall_i) begin
        if (position_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected position beat: expected none, got %0d",
                   $time, position_value_i);
        end else begin
          want = position_q.pop_front();
          if (position_value_i !== want) begin
            mismatch_cnt++;
            $display("%0t: position_value mismatch: expected %0d, got %0d",
                     $time, want, position_value_i);
          end
        end
      end
      // edge beat
      if (in_valid_i && !in_stall_i) begin
        position_q.push_back(step_position(edge_pin_i, edge_rising_i, other_level_i));
      end
      mismatch_cnt_o <= mismatch_cnt;
      pending_o      <= position_q.size();
    end
  end

endmodule

>>> bench/quadrature_counter_clamped_scaled_tb.sv
// ----------------------------------------------------------------------------
// quadrature_counter_clamped_scaled_tb: top of the position counter bench
// Drives edge beats and register writes: a directed pass over edge kinds,
// step, bound and load corner cases, then random quadrature walks with noise
// under changing settings, with random gaps and stalls and one long hold-off.
// ----------------------------------------------------------------------------
module quadrature_counter_clamped_scaled_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_AFTER   = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic                                  clk        = 1'b0;
  logic                                  rst_n      = 1'b0;
  logic                                  in_valid   = 1'b0;
  logic                                  in_stall;
  logic                                  edge_pin   = 1'b0;
  logic                                  edge_rising = 1'b0;
  logic                                  other_level = 1'b0;
  logic                                  out_valid;
  logic                                  out_stall  = 1'b0;
  logic signed [qcs_pkg::VALUE_WIDTH-1:0] position_value;
  logic                                  cfg_we     = 1'b0;
  logic [1:0]                            cfg_addr   = qcs_pkg::REG_STEP;
  logic [qcs_pkg::VALUE_WIDTH-1:0]       cfg_wdata  = '0;

  int   mismatch_cnt;
  int   pending;
  int   cycle_cnt   = 0;
  int   items_sent  = 0;
  logic idle_en     = 1'b1;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  logic enc_a       = 1'b0;
  logic enc_b       = 1'b0;

  quadrature_counter_clamped_scaled u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .edge_pin_i       (edge_pin),
    .edge_rising_i    (edge_rising),
    .other_level_i    (other_level),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .position_value_o (position_value),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata)
  );

  qcs_position_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .edge_pin_i       (edge_pin),
    .edge_rising_i    (edge_rising),
    .other_level_i    (other_level),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .position_value_i (position_value),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_cnt_o   (mismatch_cnt),
    .pending_o        (pending)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("quadrature_counter_clamped_scaled test failed");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int span;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_en && $urandom_range(0, 1) == 1) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 17);
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 30);
        repeat (span) @(posedge clk);
      end
    end
  end

  // one register write, with the enable dropped in the cycle after
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // one edge beat, maybe after a gap; returns at the accepting edge
  task automatic send_edge(input logic pin, input logic rising, input logic other);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    edge_pin    <= pin;
    edge_rising <= rising;
    other_level <= other;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // stop offering and let every owed position come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // legal encoder walk in runs of one direction, with stray beats mixed in
  task automatic quad_walk(input int n);
    int   run;
    logic up;
    logic pin;
    logic rising;
    logic other;
    run = 0;
    up  = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        up  = 1'($urandom_range(0, 1));
        run = $urandom_range(1, 50);
      end
      run--;
      if ($urandom_range(0, 9) == 0) begin
        // stray beat, line levels left alone
        send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        pin = (enc_a == enc_b) ? !up : up;
        if (pin) begin
          enc_b  = !enc_b;
          rising = enc_b;
          other  = enc_a;
        end else begin
          enc_a  = !enc_a;
          rising = enc_a;
          other  = enc_b;
        end
        send_edge(pin, rising, other);
      end
    end
  endtask

  // random step, bounds and load
  task automatic random_config();
    int sel;
    int lo;
    int hi;
    int st;
    if ($urandom_range(0, 1) == 1) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       st = 0;
        1:       st = 255;
        2:       st = $urandom_range(1, 255);
        default: st = $urandom_range(1, 6);
      endcase
      write_reg(qcs_pkg::REG_STEP, 16'(st));
    end
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        lo = -32768;
        hi = 32767;
      end
      1: begin
        // crossed bounds
        lo = $urandom_range(1, 30);
        hi = -int'($urandom_range(0, 30));
      end
      2: begin
        lo = int'($urandom_range(0, 40)) - 20;
        hi = lo;
      end
      3: begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
      end
      default: begin
        lo = -int'($urandom_range(0, 40));
        hi = $urandom_range(0, 40);
      end
    endcase
    write_reg(qcs_pkg::REG_MIN, 16'(lo));
    write_reg(qcs_pkg::REG_MAX, 16'(hi));
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(qcs_pkg::REG_INIT, 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(qcs_pkg::REG_INIT, 16'(int'($urandom_range(0, 90)) - 45));
      end
    end
    // step change after the load, count not rescaled
    if ($urandom_range(0, 5) == 0) begin
      write_reg(qcs_pkg::REG_STEP, 16'($urandom_range(1, 8)));
    end
  endtask

  // stimulus
  initial begin
    int first_random;
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, every edge kind
    for (int k = 0; k < 8; k++) begin
      send_edge(k[2], k[1], k[0]);
    end
    wait_idle();

    // zero step behaves as one
    write_reg(qcs_pkg::REG_STEP, 16'd0);
    write_reg(qcs_pkg::REG_INIT, 16'd5);
    send_edge(1'b0, 1'b1, 1'b0);
    send_edge(1'b1, 1'b1, 1'b0);
    send_edge(1'b1, 1'b0, 1'b0);
    wait_idle();

    // largest step, pinned at the top then the bottom of the full range
    write_reg(qcs_pkg::REG_STEP, 16'd255);
    write_reg(qcs_pkg::REG_MIN, 16'h8000);
    write_reg(qcs_pkg::REG_MAX, 16'h7fff);
    write_reg(qcs_pkg::REG_INIT, 16'h7fff);
    repeat (3) send_edge(1'b0, 1'b1, 1'b0);
    wait_idle();
    write_reg(qcs_pkg::REG_INIT, 16'h8000);
    repeat (3) send_edge(1'b0, 1'b0, 1'b0);
    wait_idle();

    // lower bound above upper bound
    write_reg(qcs_pkg::REG_STEP, 16'd1);
    write_reg(qcs_pkg::REG_MIN, 16'd10);
    write_reg(qcs_pkg::REG_MAX, 16'hfff6);
    write_reg(qcs_pkg::REG_INIT, 16'd0);
    send_edge(1'b0, 1'b1, 1'b0);
    send_edge(1'b0, 1'b0, 1'b0);
    send_edge(1'b1, 1'b1, 1'b1);
    wait_idle();

    // step changed after the load keeps the raw count
    write_reg(qcs_pkg::REG_MIN, 16'h8000);
    write_reg(qcs_pkg::REG_MAX, 16'h7fff);
    write_reg(qcs_pkg::REG_STEP, 16'd3);
    write_reg(qcs_pkg::REG_INIT, 16'd100);
    write_reg(qcs_pkg::REG_STEP, 16'd1);
    send_edge(1'b0, 1'b1, 1'b0);
    send_edge(1'b1, 1'b0, 1'b0);
    wait_idle();
    write_reg(qcs_pkg::REG_STEP, 16'd255);
    send_edge(1'b0, 1'b1, 1'b0);
    wait_idle();

    // random walks under random settings, quiet at the end
    first_random = items_sent;
    phase = 0;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      idle_en <= (items_sent - first_random < CALM_AFTER);
      if (phase == 3) begin
        hold_req <= 1'b1;
      end
      random_config();
      quad_walk($urandom_range(10, 80));
      wait_idle();
      phase++;
    end

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("quadrature_counter_clamped_scaled test passed");
    end else begin
      $display("quadrature_counter_clamped_scaled test failed");
    end
    $finish;
  end

endmodule
